@@ rtl/kvs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the keyframe vector sampler.
package kvs_pkg;

  localparam int MAX_KEYS  = 64;
  localparam int KEY_AW    = $clog2(MAX_KEYS);
  localparam int COUNT_W   = 7;
  localparam int TIME_W    = 24;
  localparam int VALUE_W   = 32;
  localparam int FRAC_W    = 16;
  localparam int FACTOR_W  = FRAC_W + 1;
  localparam int DIFF_W    = VALUE_W + 1;
  localparam int PROD_W    = FACTOR_W + 1 + DIFF_W;

  localparam logic [FACTOR_W-1:0] FACTOR_ZERO = '0;
  localparam logic [FACTOR_W-1:0] FACTOR_ONE  = FACTOR_W'(1) << FRAC_W;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic        [TIME_W-1:0]  stamp;
    logic signed [VALUE_W-1:0] x;
    logic signed [VALUE_W-1:0] y;
    logic signed [VALUE_W-1:0] z;
  } key_t;

endpackage

@@ rtl/kvs_key_mem.sv @@
`timescale 1ns / 1ps
// Key store: one write port, one registered read port.
module kvs_key_mem (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [kvs_pkg::KEY_AW-1:0] wr_addr_i,
  input  kvs_pkg::key_t             wr_data_i,
  input  logic                      rd_en_i,
  input  logic [kvs_pkg::KEY_AW-1:0] rd_addr_i,
  output kvs_pkg::key_t             rd_data_o
);
  import kvs_pkg::*;

  key_t mem_q [MAX_KEYS];
  key_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/kvs_div.sv @@
`timescale 1ns / 1ps
// Restoring divider: factor = (num << 16) / den, one quotient bit per cycle.
module kvs_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [kvs_pkg::TIME_W-1:0]   num_i,
  input  logic [kvs_pkg::TIME_W-1:0]   den_i,
  output logic                         done_o,
  output logic [kvs_pkg::FACTOR_W-1:0] quot_o
);
  import kvs_pkg::*;

  localparam int CNT_W = $clog2(FACTOR_W + 1);

  logic [TIME_W:0]     rem_q;
  logic [TIME_W-1:0]   den_q;
  logic [FACTOR_W-1:0] quot_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                run_q;
  logic                done_q;

  logic                ge;
  logic [TIME_W:0]     rem_sub;

  // num <= den on entry, so the remainder stays below 2*den
  assign ge      = rem_q >= {1'b0, den_q};
  assign rem_sub = ge ? (rem_q - {1'b0, den_q}) : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= {1'b0, num_i};
        den_q  <= den_i;
        quot_q <= '0;
        cnt_q  <= CNT_W'(FACTOR_W);
        run_q  <= 1'b1;
      end else if (run_q) begin
        rem_q  <= {rem_sub[TIME_W-1:0], 1'b0};
        quot_q <= {quot_q[FACTOR_W-2:0], ge};
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ rtl/kvs_lerp.sv @@
`timescale 1ns / 1ps
// Shared multiply-add: blends the three axes one after another.
module kvs_lerp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [kvs_pkg::FACTOR_W-1:0]        factor_i,
  input  kvs_pkg::key_t                       key_a_i,
  input  kvs_pkg::key_t                       key_b_i,
  output logic                                done_o,
  output logic signed [kvs_pkg::VALUE_W-1:0]  x_o,
  output logic signed [kvs_pkg::VALUE_W-1:0]  y_o,
  output logic signed [kvs_pkg::VALUE_W-1:0]  z_o
);
  import kvs_pkg::*;

  typedef enum logic [1:0] {
    L_IDLE,
    L_DIFF,
    L_MUL,
    L_ADD
  } lerp_state_e;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_e;

  lerp_state_e state_q;
  axis_e       axis_q;
  logic        done_q;

  logic signed [DIFF_W-1:0]  diff_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [VALUE_W-1:0] x_q, y_q, z_q;

  logic signed [VALUE_W-1:0] s_val, e_val, sum;

  always_comb begin
    unique case (axis_q)
      AX_X:    begin s_val = key_a_i.x; e_val = key_b_i.x; end
      AX_Y:    begin s_val = key_a_i.y; e_val = key_b_i.y; end
      AX_Z:    begin s_val = key_a_i.z; e_val = key_b_i.z; end
      default: begin s_val = key_a_i.x; e_val = key_b_i.x; end
    endcase
  end

  // floor(factor*d / 2^16); the true result lies between start and end
  assign sum = s_val + prod_q[FRAC_W +: VALUE_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      axis_q  <= AX_X;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        L_IDLE: begin
          if (start_i) begin
            axis_q  <= AX_X;
            state_q <= L_DIFF;
          end
        end
        L_DIFF: begin
          diff_q  <= DIFF_W'(e_val) - DIFF_W'(s_val);
          state_q <= L_MUL;
        end
        L_MUL: begin
          prod_q  <= $signed({1'b0, factor_i}) * diff_q;
          state_q <= L_ADD;
        end
        L_ADD: begin
          unique case (axis_q)
            AX_X: begin
              x_q     <= sum;
              axis_q  <= AX_Y;
              state_q <= L_DIFF;
            end
            AX_Y: begin
              y_q     <= sum;
              axis_q  <= AX_Z;
              state_q <= L_DIFF;
            end
            default: begin
              z_q     <= sum;
              done_q  <= 1'b1;
              state_q <= L_IDLE;
            end
          endcase
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule

@@ rtl/keyframe_vector_sampler_core.sv @@
`timescale 1ns / 1ps
// Top level of the keyframe vector sampler: sequencer, key store and arithmetic units.
//
//  channel  handshake                  payload
//  -------  -------------------------  ------------------------------------------------
//  command  start_i / busy_o           operation_i, key_*_i, value_[xyz]_i, sample_time_i
//  result   done_o (one-cycle strobe)  out_[xyz]_o, segment_start_o, out_of_range_o
//  config   cfg_valid_i / cfg_ready_o  cfg_data_i (key count)
//
// An item is taken when start_i is high and busy_o is low; a key write lands in the
// store at that edge and leaves busy_o low. A sample holds busy_o high until its result
// strobe: with one key in use it reads key 0 and hands it back unchanged, else it scans
// keys through the single store port, fetches the two segment keys, runs the 17-step
// divider when t is inside a proper segment and blends the axes. Reset clears the
// sequencer and sets the key count to 1, not the store. The receiver cannot stall.
module keyframe_vector_sampler_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic                                 operation_i,
  input  logic [kvs_pkg::KEY_AW-1:0]           key_index_i,
  input  logic [kvs_pkg::TIME_W-1:0]           key_time_i,
  input  logic signed [kvs_pkg::VALUE_W-1:0]   value_x_i,
  input  logic signed [kvs_pkg::VALUE_W-1:0]   value_y_i,
  input  logic signed [kvs_pkg::VALUE_W-1:0]   value_z_i,
  input  logic [kvs_pkg::TIME_W-1:0]           sample_time_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [kvs_pkg::COUNT_W-1:0]          cfg_data_i,
  output logic                                 done_o,
  output logic signed [kvs_pkg::VALUE_W-1:0]   out_x_o,
  output logic signed [kvs_pkg::VALUE_W-1:0]   out_y_o,
  output logic signed [kvs_pkg::VALUE_W-1:0]   out_z_o,
  output logic [kvs_pkg::KEY_AW-1:0]           segment_start_o,
  output logic                                 out_of_range_o
);
  import kvs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ONE_RD,
    S_ONE_OUT,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SEG_RD,
    S_NXT_RD,
    S_NXT_WAIT,
    S_FACT,
    S_DIV,
    S_LERP_GO,
    S_LERP
  } seq_state_e;

  seq_state_e state_q;
  logic       busy_q;
  logic       done_q;

  logic [COUNT_W-1:0]  count_q;
  logic [KEY_AW-1:0]   last_q;
  logic [KEY_AW-1:0]   idx_q;
  logic [KEY_AW-1:0]   seg_q;
  logic [TIME_W-1:0]   t_q;
  key_t                key_a_q;
  key_t                key_b_q;
  logic [FACTOR_W-1:0] factor_q;
  logic                flag_q;

  logic signed [VALUE_W-1:0] out_x_q, out_y_q, out_z_q;
  logic [KEY_AW-1:0]         out_seg_q;
  logic                      out_flag_q;

  logic               accept;
  logic [KEY_AW-1:0]  kc_last;
  logic               mem_wr_en;
  key_t               mem_wr_data;
  logic               mem_rd_en;
  logic [KEY_AW-1:0]  mem_rd_addr;
  key_t               mem_rd_data;

  logic                div_start;
  logic                div_done;
  logic [FACTOR_W-1:0] div_quot;
  logic                lerp_start;
  logic                lerp_done;
  logic signed [VALUE_W-1:0] lerp_x, lerp_y, lerp_z;

  assign accept = start_i && !busy_q;

  // Index of the last key in use; a count of zero acts as one, above the
  // store size as the store size.
  always_comb begin
    if (count_q == '0) begin
      kc_last = '0;
    end else if (count_q > COUNT_W'(MAX_KEYS)) begin
      kc_last = KEY_AW'(MAX_KEYS - 1);
    end else begin
      kc_last = KEY_AW'(count_q - 1'b1);
    end
  end

  // Key writes land in the store on the accepting edge.
  assign mem_wr_en         = accept && (operation_i == OP_WRITE);
  assign mem_wr_data.stamp = key_time_i;
  assign mem_wr_data.x     = value_x_i;
  assign mem_wr_data.y     = value_y_i;
  assign mem_wr_data.z     = value_z_i;

  // Drive the single read port from the sequencer state.
  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    unique case (state_q)
      S_ONE_RD:  begin mem_rd_en = 1'b1; mem_rd_addr = '0;           end
      S_SRCH_RD: begin mem_rd_en = 1'b1; mem_rd_addr = idx_q;        end
      S_SEG_RD:  begin mem_rd_en = 1'b1; mem_rd_addr = seg_q;        end
      S_NXT_RD:  begin mem_rd_en = 1'b1; mem_rd_addr = seg_q + 1'b1; end
      default:   begin mem_rd_en = 1'b0; mem_rd_addr = '0;           end
    endcase
  end

  // Divide only for a proper segment with t inside [t0, t1].
  assign div_start  = (state_q == S_FACT) && (key_b_q.stamp > key_a_q.stamp) &&
                      (t_q >= key_a_q.stamp) && (t_q <= key_b_q.stamp);
  assign lerp_start = (state_q == S_LERP_GO);

  kvs_key_mem u_key_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (key_index_i),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  kvs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (t_q - key_a_q.stamp),
    .den_i   (key_b_q.stamp - key_a_q.stamp),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  kvs_lerp u_lerp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (lerp_start),
    .factor_i (factor_q),
    .key_a_i  (key_a_q),
    .key_b_i  (key_b_q),
    .done_o   (lerp_done),
    .x_o      (lerp_x),
    .y_o      (lerp_y),
    .z_o      (lerp_z)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= COUNT_W'(1);
    end else begin
      done_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept && (operation_i == OP_SAMPLE)) begin
            busy_q <= 1'b1;
            t_q    <= sample_time_i;
            last_q <= kc_last;
            idx_q  <= KEY_AW'(1);
            if (kc_last == '0) begin
              state_q <= S_ONE_RD;
            end else begin
              state_q <= S_SRCH_RD;
            end
          end
        end
        S_ONE_RD: state_q <= S_ONE_OUT;
        S_ONE_OUT: begin
          // single key: hand it back unchanged
          out_x_q    <= mem_rd_data.x;
          out_y_q    <= mem_rd_data.y;
          out_z_q    <= mem_rd_data.z;
          out_seg_q  <= '0;
          out_flag_q <= 1'b0;
          done_q     <= 1'b1;
          busy_q     <= 1'b0;
          state_q    <= S_IDLE;
        end
        S_SRCH_RD: state_q <= S_SRCH_CMP;
        S_SRCH_CMP: begin
          // first successor later than t picks the segment; none falls back to key 0
          if (t_q < mem_rd_data.stamp) begin
            seg_q   <= idx_q - 1'b1;
            state_q <= S_SEG_RD;
          end else if (idx_q == last_q) begin
            seg_q   <= '0;
            state_q <= S_SEG_RD;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_SRCH_RD;
          end
        end
        S_SEG_RD: state_q <= S_NXT_RD;
        S_NXT_RD: begin
          key_a_q <= mem_rd_data;
          state_q <= S_NXT_WAIT;
        end
        S_NXT_WAIT: begin
          key_b_q <= mem_rd_data;
          state_q <= S_FACT;
        end
        S_FACT: begin
          if (div_start) begin
            flag_q  <= 1'b0;
            state_q <= S_DIV;
          end else if ((key_b_q.stamp <= key_a_q.stamp) || (t_q < key_a_q.stamp)) begin
            // degenerate segment or time before it: hold the start key
            factor_q <= FACTOR_ZERO;
            flag_q   <= 1'b1;
            state_q  <= S_LERP_GO;
          end else begin
            // time past the segment: clamp to the end key
            factor_q <= FACTOR_ONE;
            flag_q   <= 1'b1;
            state_q  <= S_LERP_GO;
          end
        end
        S_DIV: begin
          if (div_done) begin
            factor_q <= div_quot;
            state_q  <= S_LERP_GO;
          end
        end
        S_LERP_GO: state_q <= S_LERP;
        S_LERP: begin
          if (lerp_done) begin
            out_x_q    <= lerp_x;
            out_y_q    <= lerp_y;
            out_z_q    <= lerp_z;
            out_seg_q  <= seg_q;
            out_flag_q <= flag_q;
            done_q     <= 1'b1;
            busy_q     <= 1'b0;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o          = busy_q;
  assign cfg_ready_o     = !busy_q;
  assign done_o          = done_q;
  assign out_x_o         = out_x_q;
  assign out_y_o         = out_y_q;
  assign out_z_o         = out_z_q;
  assign segment_start_o = out_seg_q;
  assign out_of_range_o  = out_flag_q;

endmodule
